// File: design/stki_pkg.sv
// Shared constants and arithmetic helpers for the spline table kernel integrator.
`timescale 1ns / 1ps
package stki_pkg;
  localparam int ORDER_COUNT_DEF = 16;
  localparam int TABLE_DEPTH_DEF = 1024;

  localparam logic [2:0] CFG_SAMPLE_STEP = 3'd0;
  localparam logic [2:0] CFG_STEP_RECIP  = 3'd1;
  localparam logic [2:0] CFG_UPPER_LIMIT = 3'd2;
  localparam logic [2:0] CFG_RADIUS      = 3'd3;
  localparam logic [2:0] CFG_INTERP_MODE = 3'd4;
  localparam logic [2:0] CFG_ORDERS      = 3'd5;

  localparam logic [1:0] REQ_WRITE_ENTRY = 2'd0;
  localparam logic [1:0] REQ_WRITE_START = 2'd1;
  localparam logic [1:0] REQ_SAMPLE      = 2'd2;
  localparam logic [1:0] REQ_QUERY       = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_ORD  = 2'd1;
  localparam logic [1:0] ST_ABOVE    = 2'd2;
  localparam logic [1:0] ST_PAST_END = 2'd3;

  localparam logic [1:0] SH_16 = 2'd0;
  localparam logic [1:0] SH_24 = 2'd1;
  localparam logic [1:0] SH_32 = 2'd2;

  localparam logic [63:0] Q16_ONE  = 64'd65536;
  localparam logic [63:0] H26_INIT = 64'd715827882;
  localparam logic [63:0] DIV6_MAGIC = 64'hAAAA_AAAA_AAAA_AAAB;
  localparam logic [63:0] S64_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN  = 64'h8000_0000_0000_0000;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] mul_finish(input logic [127:0] prod, input logic neg,
                                             input logic [1:0] shc);
    logic        ovf;
    logic [63:0] q;
    case (shc)
      SH_16: begin
        ovf = |prod[127:80];
        q   = prod[79:16];
      end
      SH_24: begin
        ovf = |prod[127:88];
        q   = prod[87:24];
      end
      default: begin
        ovf = |prod[127:96];
        q   = prod[95:32];
      end
    endcase
    if (ovf) return neg ? S64_MIN : S64_MAX;
    if (neg) return q[63] ? S64_MIN : (64'd0 - q);
    return q[63] ? S64_MAX : q;
  endfunction
endpackage

// File: design/spline_table_kernel_integrator_core.sv
// Top level: table memory, sequencer, shared multiplier and output register.
`timescale 1ns / 1ps
// Point queries and integration samples run one at a time through a sequencer
// around one memory of {curvature, value} words with a registered read. A table
// or start write completes when it is accepted. Other requests pass the range
// check, then the table index and reads, then a linear or cubic interpolation;
// a sample then adds its integration product, and a last sample also gives its
// result. A request rejected at the range check, or whose entry lies past the
// table end, skips the remaining steps. A stalled result holds the sequencer.
// Interpolation and integration products pass through one shared 32x32 multiplier.
// A write to sample_step recomputes step^2/6 by a reciprocal multiplication,
// during which inputs and register writes are stalled.
module spline_table_kernel_integrator_core #(
  parameter int ORDER_COUNT = stki_pkg::ORDER_COUNT_DEF,
  parameter int TABLE_DEPTH = stki_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [3:0]  in_order_index,
  input  logic [9:0]  in_entry_index,
  input  logic signed [31:0] in_func_value,
  input  logic signed [31:0] in_curv_value,
  input  logic [31:0] in_position,
  input  logic [31:0] in_k_weight,
  input  logic signed [31:0] in_f_value,
  input  logic signed [31:0] in_g_value,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [63:0] out_result_value,
  output logic        out_is_integral,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int MEM_DEPTH = ORDER_COUNT * TABLE_DEPTH;
  localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int OW = (ORDER_COUNT > 1) ? $clog2(ORDER_COUNT) : 1;

  localparam logic [4:0] S_IDLE = 5'd0,  S_ARG = 5'd1,  S_CHK = 5'd2,  S_IDX = 5'd3;
  localparam logic [4:0] S_RD0  = 5'd4,  S_RD1 = 5'd5,  S_RD2 = 5'd6,  S_C1  = 5'd7;
  localparam logic [4:0] S_C2   = 5'd8,  S_C3  = 5'd9,  S_C4  = 5'd10, S_L1  = 5'd11;
  localparam logic [4:0] S_L2   = 5'd12, S_I1  = 5'd13, S_I2  = 5'd14, S_I3  = 5'd15;
  localparam logic [4:0] S_I4   = 5'd16, S_FIN = 5'd17, S_EMIT = 5'd18;

  logic [31:0] step_r, recip_r, upper_r, radius_r;
  logic        mode_r;
  logic [4:0]  orders_r;
  logic [63:0] h26_r;
  logic        div_load_r, div_busy_r;
  logic [1:0]  div_cnt_r;
  logic [63:0] div_sq_r;
  logic [127:0] div_acc_r, div_sum, div_pp_sh;
  logic [31:0] div_pa, div_pb;
  logic [63:0] div_pp;

  logic [63:0] mem [MEM_DEPTH];
  logic [63:0] rd_q_r;
  logic [AW-1:0] rd_addr, base_r, base_nxt;
  logic [31:0] start_tab [ORDER_COUNT];

  logic [4:0]  state_r, state_nxt;
  logic [1:0]  req_r;
  logic [3:0]  ord_r;
  logic [31:0] pos_r, dk_r;
  logic signed [31:0] f_r, g_r;
  logic        last_r;
  logic [47:0] x_r, k2_r;
  logic [63:0] p_r;
  logic [16:0] aq_r;
  logic [15:0] bq_r;
  logic [63:0] w0_r, s_r, t_r, inner_r, m_r, j_r, acc_r;
  logic [1:0]  sticky_r;
  logic [63:0] res_r;
  logic [1:0]  st_r;
  logic        isint_r;
  logic        out_valid_r;
  logic [63:0] out_res_r;
  logic [1:0]  out_st_r;
  logic        out_int_r;

  logic        in_acc, ord_ok, is_mul, mul_last;
  logic [31:0] start_v, idx_v;
  logic [2:0]  mc_r;
  logic [63:0] mul_x, mul_y, mx, my, mr;
  logic [1:0]  mul_shc;
  logic        mul_neg;
  logic [31:0] pa, pb;
  logic [63:0] pp;
  logic [127:0] pp_sh, prod_r;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE) || div_busy_r || div_load_r;
  assign cfg_ready = !div_busy_r && !div_load_r;
  assign out_valid = out_valid_r;
  assign out_result_value = out_res_r;
  assign out_is_integral  = out_int_r;
  assign out_status       = out_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= 32'd65536;
      recip_r  <= 32'd65536;
      upper_r  <= 32'hFFFF_FFFF;
      radius_r <= 32'd65536;
      mode_r   <= 1'b1;
      orders_r <= 5'd16;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        stki_pkg::CFG_SAMPLE_STEP: step_r   <= cfg_data;
        stki_pkg::CFG_STEP_RECIP:  recip_r  <= cfg_data;
        stki_pkg::CFG_UPPER_LIMIT: upper_r  <= cfg_data;
        stki_pkg::CFG_RADIUS:      radius_r <= cfg_data;
        stki_pkg::CFG_INTERP_MODE: mode_r   <= cfg_data[0];
        stki_pkg::CFG_ORDERS:      orders_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // step^2 / 6 as (step^2 * magic) >> 66, one 32x32 partial product a cycle
  assign div_pa = div_cnt_r[0] ? div_sq_r[63:32] : div_sq_r[31:0];
  assign div_pb = div_cnt_r[1] ? stki_pkg::DIV6_MAGIC[63:32] : stki_pkg::DIV6_MAGIC[31:0];
  assign div_pp = 64'(div_pa) * 64'(div_pb);

  always_comb begin
    case (div_cnt_r)
      2'd0:    div_pp_sh = {64'd0, div_pp};
      2'd3:    div_pp_sh = {div_pp, 64'd0};
      default: div_pp_sh = {32'd0, div_pp, 32'd0};
    endcase
  end

  assign div_sum = div_acc_r + div_pp_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h26_r      <= stki_pkg::H26_INIT;
      div_load_r <= 1'b0;
      div_busy_r <= 1'b0;
      div_cnt_r  <= '0;
    end else begin
      div_load_r <= cfg_valid && cfg_ready && (cfg_index == stki_pkg::CFG_SAMPLE_STEP);
      if (div_load_r) begin
        div_sq_r   <= 64'(step_r) * 64'(step_r);
        div_acc_r  <= '0;
        div_cnt_r  <= 2'd0;
        div_busy_r <= 1'b1;
      end else if (div_busy_r) begin
        div_acc_r <= div_sum;
        div_cnt_r <= div_cnt_r + 2'd1;
        if (div_cnt_r == 2'd3) begin
          div_busy_r <= 1'b0;
          h26_r      <= {2'b00, div_sum[127:66]};
        end
      end
    end
  end

  assign idx_v    = p_r[63:32];
  assign base_nxt = AW'(32'(ord_r) * 32'(TABLE_DEPTH) + idx_v);
  assign rd_addr  = (state_r == S_RD0) ? base_nxt : AW'(base_r + AW'(1));

  always_ff @(posedge clk) begin
    if (in_acc && in_req_type == stki_pkg::REQ_WRITE_ENTRY &&
        32'(in_order_index) < 32'(ORDER_COUNT) && 32'(in_entry_index) < 32'(TABLE_DEPTH))
      mem[AW'(32'(in_order_index) * 32'(TABLE_DEPTH) + 32'(in_entry_index))] <=
        {in_curv_value, in_func_value};
    rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_req_type == stki_pkg::REQ_WRITE_START &&
        32'(in_order_index) < 32'(ORDER_COUNT))
      start_tab[OW'(in_order_index)] <= in_position;
  end

  assign start_v = start_tab[OW'(ord_r)];
  assign ord_ok  = (5'(ord_r) < orders_r) && (32'(ord_r) < 32'(ORDER_COUNT));

  assign is_mul = (state_r >= S_C1) && (state_r <= S_I4);
  assign mul_last = (mc_r == 3'd4);

  always_comb begin
    mul_x   = j_r;
    mul_y   = 64'(k2_r);
    mul_shc = stki_pkg::SH_16;
    case (state_r)
      S_C1: begin
        mul_x = 64'(aq_r) + stki_pkg::Q16_ONE;
        mul_y = {{32{w0_r[63]}}, w0_r[63:32]};
      end
      S_C2: begin
        mul_x = (stki_pkg::Q16_ONE << 1) - 64'(aq_r);
        mul_y = {{32{rd_q_r[63]}}, rd_q_r[63:32]};
      end
      S_C3: begin
        mul_x = 64'(aq_r);
        mul_y = s_r;
      end
      S_C4: begin
        mul_x   = t_r;
        mul_y   = h26_r;
        mul_shc = stki_pkg::SH_32;
      end
      S_L1: begin
        mul_x = 64'(aq_r);
        mul_y = {{32{w0_r[31]}}, w0_r[31:0]};
      end
      S_L2: begin
        mul_x = 64'(bq_r);
        mul_y = inner_r;
      end
      S_I2: begin
        mul_y   = 64'(signed'(f_r));
        mul_shc = stki_pkg::SH_24;
      end
      S_I3: begin
        mul_y   = 64'(signed'(g_r));
        mul_shc = stki_pkg::SH_24;
      end
      S_I4: mul_y = 64'(dk_r);
      default: ;
    endcase
  end

  assign mul_neg = mul_x[63] ^ mul_y[63];
  assign mx = mul_x[63] ? (64'd0 - mul_x) : mul_x;
  assign my = mul_y[63] ? (64'd0 - mul_y) : mul_y;
  assign pa = mc_r[0] ? mx[63:32] : mx[31:0];
  assign pb = mc_r[1] ? my[63:32] : my[31:0];
  assign pp = 64'(pa) * 64'(pb);

  always_comb begin
    case (mc_r[1:0])
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  assign mr = stki_pkg::mul_finish(prod_r, mul_neg, mul_shc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mc_r <= '0;
    end else if (is_mul) begin
      mc_r <= mul_last ? 3'd0 : mc_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (is_mul && !mul_last)
      prod_r <= (mc_r == 3'd0) ? pp_sh : prod_r + pp_sh;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_req_type == stki_pkg::REQ_SAMPLE ||
                       in_req_type == stki_pkg::REQ_QUERY))
          state_nxt = S_ARG;
      end
      S_ARG: state_nxt = S_CHK;
      S_CHK: begin
        if (req_r == stki_pkg::REQ_QUERY) begin
          if (!ord_ok || x_r < 48'(start_v) || x_r > 48'(upper_r)) state_nxt = S_EMIT;
          else state_nxt = S_IDX;
        end else begin
          if (!ord_ok || x_r > 48'(upper_r)) state_nxt = S_FIN;
          else if (f_r != 0 && g_r != 0 && x_r >= 48'(start_v)) state_nxt = S_IDX;
          else state_nxt = S_FIN;
        end
      end
      S_IDX: state_nxt = S_RD0;
      S_RD0: begin
        if (idx_v >= 32'(TABLE_DEPTH - 1))
          state_nxt = (req_r == stki_pkg::REQ_QUERY) ? S_EMIT : S_FIN;
        else state_nxt = S_RD1;
      end
      S_RD1: state_nxt = S_RD2;
      S_RD2: state_nxt = mode_r ? S_C1 : S_L1;
      S_C1, S_C3, S_C4, S_L1, S_I1, S_I2, S_I3: begin
        if (mul_last) state_nxt = 5'(state_r + 5'd1);
      end
      S_C2: if (mul_last) state_nxt = S_C3;
      S_L2: begin
        if (mul_last) state_nxt = (req_r == stki_pkg::REQ_QUERY) ? S_EMIT : S_I1;
      end
      S_I4: if (mul_last) state_nxt = S_FIN;
      S_FIN: state_nxt = last_r ? S_EMIT : S_IDLE;
      S_EMIT: if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      acc_r    <= '0;
      sticky_r <= stki_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_CHK: begin
          if (req_r == stki_pkg::REQ_SAMPLE && sticky_r == stki_pkg::ST_OK) begin
            if (!ord_ok) sticky_r <= stki_pkg::ST_BAD_ORD;
            else if (x_r > 48'(upper_r)) sticky_r <= stki_pkg::ST_ABOVE;
          end
        end
        S_RD0: begin
          if (req_r == stki_pkg::REQ_SAMPLE && idx_v >= 32'(TABLE_DEPTH - 1) &&
              sticky_r == stki_pkg::ST_OK)
            sticky_r <= stki_pkg::ST_PAST_END;
        end
        S_I4: if (mul_last) acc_r <= stki_pkg::sat_add(acc_r, mr);
        S_FIN: begin
          if (last_r) begin
            acc_r    <= '0;
            sticky_r <= stki_pkg::ST_OK;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r  <= in_req_type;
      ord_r  <= in_order_index;
      pos_r  <= in_position;
      dk_r   <= in_k_weight;
      f_r    <= in_f_value;
      g_r    <= in_g_value;
      last_r <= in_last;
    end
    case (state_r)
      S_ARG: begin
        x_r  <= (req_r == stki_pkg::REQ_SAMPLE) ?
                48'((64'(pos_r) * 64'(radius_r)) >> 16) : 48'(pos_r);
        k2_r <= 48'((64'(pos_r) * 64'(pos_r)) >> 16);
      end
      S_CHK: begin
        isint_r <= 1'b0;
        res_r   <= '0;
        if (!ord_ok) st_r <= stki_pkg::ST_BAD_ORD;
        else if (x_r < 48'(start_v)) st_r <= stki_pkg::ST_OK;
        else st_r <= stki_pkg::ST_ABOVE;
      end
      S_IDX: p_r <= 64'(x_r[31:0] - start_v) * 64'(recip_r);
      S_RD0: begin
        base_r <= base_nxt;
        bq_r   <= p_r[31:16];
        aq_r   <= 17'h10000 - 17'(p_r[31:16]);
        st_r   <= stki_pkg::ST_PAST_END;
      end
      S_RD1: w0_r <= rd_q_r;
      S_RD2: inner_r <= {{32{rd_q_r[31]}}, rd_q_r[31:0]};
      S_C1: if (mul_last) s_r <= mr;
      S_C2: if (mul_last) s_r <= stki_pkg::sat_add(s_r, mr);
      S_C3: if (mul_last) t_r <= mr;
      S_C4: if (mul_last) inner_r <= stki_pkg::sat_sub(inner_r, mr);
      S_L1: if (mul_last) m_r <= mr;
      S_L2: begin
        if (mul_last) begin
          j_r   <= stki_pkg::sat_add(m_r, mr);
          res_r <= stki_pkg::sat_add(m_r, mr);
          st_r  <= stki_pkg::ST_OK;
        end
      end
      S_I1, S_I2, S_I3: if (mul_last) j_r <= mr;
      S_FIN: begin
        isint_r <= 1'b1;
        st_r    <= sticky_r;
        res_r   <= (sticky_r == stki_pkg::ST_OK) ?
                   64'($signed(acc_r + 64'(acc_r[63])) >>> 1) : 64'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_EMIT && (!out_valid_r || !out_stall)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EMIT && (!out_valid_r || !out_stall)) begin
      out_res_r <= res_r;
      out_st_r  <= st_r;
      out_int_r <= isint_r;
    end
  end
endmodule
